// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers; clk and rst are taken from the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AST_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define AST_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/nvd_pkg.sv =====
package nvd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 32;
  localparam int unsigned TotalW = 37;

  localparam logic [ByteW-1:0] FAST_HDR = 8'hF0;
  localparam logic [2:0]       FAST_CNT = 3'd4;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_FAST,
    PH_VALUE,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic              valid;
    logic [ValueW-1:0] value;
    logic              last;
    logic [TotalW-1:0] consumed;
  } nvd_result_t;

endpackage

// ===== hw/rtl/nvd_core.sv =====
`include "assert_macros.svh"

module nvd_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step_en,
  input  logic [nvd_pkg::ByteW-1:0]   data_byte,
  input  logic                        start_req,
  input  logic [nvd_pkg::ValueW-1:0]  value_count,
  output nvd_pkg::nvd_result_t        res
);
  import nvd_pkg::*;

  phase_t             phase, phase_next, phase_eff;
  logic [2:0]         fast_left, fast_left_next, fast_e;
  logic               slot, slot_next, slot_e;
  logic [3:0]         high_code, high_code_next, high_e;
  logic [4:0]         bytes_left, bytes_left_next, bl_e, bl_dec;
  logic [3:0]         byte_pos, byte_pos_next, bp_e;
  logic [ValueW-1:0]  accumulator, accumulator_next, acc_e, acc_upd;
  logic [ValueW-1:0]  values_done, values_done_next, vd_e;
  logic [TotalW-1:0]  byte_total, byte_total_next, bt_e;
  logic               emit;
  logic [ValueW-1:0]  emit_val;

  // Start request clears the array state before the item is used.
  always_comb begin
    if (start_req) begin
      phase_eff = PH_HEADER;
      fast_e    = '0;
      slot_e    = 1'b0;
      high_e    = '0;
      bl_e      = '0;
      bp_e      = '0;
      acc_e     = '0;
      vd_e      = '0;
      bt_e      = '0;
    end else begin
      phase_eff = phase;
      fast_e    = fast_left;
      slot_e    = slot;
      high_e    = high_code;
      bl_e      = bytes_left;
      bp_e      = byte_pos;
      acc_e     = accumulator;
      vd_e      = values_done;
      bt_e      = byte_total;
    end
    if (phase_eff == PH_HEADER && vd_e >= value_count) begin
      phase_eff = PH_DONE;
    end
  end

  always_comb begin
    phase_next       = phase_eff;
    fast_left_next   = fast_e;
    slot_next        = slot_e;
    high_code_next   = high_e;
    bytes_left_next  = bl_e;
    byte_pos_next    = bp_e;
    accumulator_next = acc_e;
    values_done_next = vd_e;
    byte_total_next  = bt_e;
    emit             = 1'b0;
    emit_val         = '0;
    acc_upd          = acc_e;
    bl_dec           = bl_e - 5'd1;
    res              = '0;

    if (phase_eff != PH_DONE) begin
      byte_total_next = bt_e + TotalW'(1);
    end

    unique case (phase_eff)
      PH_HEADER: begin
        if (data_byte == FAST_HDR) begin
          fast_left_next = FAST_CNT;
          phase_next     = PH_FAST;
        end else begin
          slot_next        = 1'b0;
          high_code_next   = data_byte[7:4];
          bytes_left_next  = {1'b0, data_byte[3:0]} + 5'd1;
          byte_pos_next    = '0;
          accumulator_next = '0;
          phase_next       = PH_VALUE;
        end
      end
      PH_FAST: begin
        fast_left_next = fast_e - 3'd1;
        if (fast_left_next == 3'd0) begin
          phase_next = PH_HEADER;
        end
        emit     = 1'b1;
        emit_val = ValueW'(data_byte);
      end
      PH_VALUE: begin
        // only the first four bytes land in the value, the rest are dropped
        if (bp_e < 4'd4) begin
          case (bp_e[1:0])
            2'd0:    acc_upd[7:0]   = acc_e[7:0]   | data_byte;
            2'd1:    acc_upd[15:8]  = acc_e[15:8]  | data_byte;
            2'd2:    acc_upd[23:16] = acc_e[23:16] | data_byte;
            default: acc_upd[31:24] = acc_e[31:24] | data_byte;
          endcase
        end
        accumulator_next = acc_upd;
        byte_pos_next    = bp_e + 4'd1;
        bytes_left_next  = bl_dec;
        if (bl_dec == 5'd0) begin
          emit     = 1'b1;
          emit_val = acc_upd;
          if (!slot_e) begin
            slot_next        = 1'b1;
            bytes_left_next  = {1'b0, high_e} + 5'd1;
            byte_pos_next    = '0;
            accumulator_next = '0;
            phase_next       = PH_VALUE;
          end else begin
            slot_next  = 1'b0;
            phase_next = PH_HEADER;
          end
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase

    if (emit) begin
      values_done_next = vd_e + ValueW'(1);
      res.valid        = 1'b1;
      res.value        = emit_val;
      if (values_done_next >= value_count) begin
        res.last     = 1'b1;
        res.consumed = byte_total_next;
        phase_next   = PH_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      fast_left   <= '0;
      slot        <= 1'b0;
      high_code   <= '0;
      bytes_left  <= '0;
      byte_pos    <= '0;
      accumulator <= '0;
      values_done <= '0;
      byte_total  <= '0;
    end else if (step_en) begin
      phase       <= phase_next;
      fast_left   <= fast_left_next;
      slot        <= slot_next;
      high_code   <= high_code_next;
      bytes_left  <= bytes_left_next;
      byte_pos    <= byte_pos_next;
      accumulator <= accumulator_next;
      values_done <= values_done_next;
      byte_total  <= byte_total_next;
    end
  end

  `AST_IMPL(a_last_ends_array, step_en && res.valid && res.last, phase_next == PH_DONE, "last item did not close the array")
  `AST_IMPL(a_done_silent, step_en && phase_eff == PH_DONE, !res.valid && byte_total_next == bt_e, "finished array produced an item")
  `AST_NEXT(a_fast_count, step_en && phase_eff == PH_HEADER && data_byte == FAST_HDR, phase == PH_FAST && fast_left == FAST_CNT, "fast group not set up")

endmodule

// ===== hw/rtl/nibble_varint_stream_decoder.sv =====
// Nibble-header group varint decoder.
// Input channel (in_valid/in_ready): one stream byte per item on data_byte;
// start_req marks the first byte of a new array and clears the counters.
// Config channel (cfg_valid/cfg_ready): cfg_data sets value_count, the number
// of values in the array; always ready, write it only while the block is idle.
// Output channel (out_valid/out_ready): one decoded 32-bit value per item;
// last flags the final value of the array and consumed_bytes then holds the
// total bytes used, headers included (zero otherwise). Bytes after the last
// value are swallowed until the next start_req.
// Throughput: one byte per cycle while the output is not stalled; the state
// update for a byte is done in the cycle it is accepted. The output register
// shows a value in the cycle after the byte that completes it is accepted.
// A single output register holds the result; while it is full and out_ready
// is low, in_ready drops and the decoder stalls. When out_ready is high a new
// byte is taken in the same cycle the held value leaves.
// Reset (rst, synchronous) empties the output register, zeroes value_count and
// puts the decoder at the start of an array.
`include "assert_macros.svh"

module nibble_varint_stream_decoder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [nvd_pkg::ByteW-1:0]   data_byte,
  input  logic                        start_req,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [nvd_pkg::ValueW-1:0]  cfg_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [nvd_pkg::ValueW-1:0]  value,
  output logic                        last,
  output logic [nvd_pkg::TotalW-1:0]  consumed_bytes
);
  import nvd_pkg::*;

  logic              in_fire;
  logic [ValueW-1:0] value_count;
  nvd_result_t       res;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      value_count <= '0;
    end else if (cfg_valid) begin
      value_count <= cfg_data;
    end
  end

  nvd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step_en     (in_fire),
    .data_byte   (data_byte),
    .start_req   (start_req),
    .value_count (value_count),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= res.valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res.valid) begin
      value          <= res.value;
      last           <= res.last;
      consumed_bytes <= res.consumed;
    end
  end

  `AST_IMPL(a_no_overwrite, out_valid && !out_ready, !in_ready, "input taken over a held item")
  `AST_IMPL(a_count_only_last, out_valid && !last, consumed_bytes == '0, "byte count on a non-final item")
  `AST_NEXT(a_result_shows, in_fire && res.valid, out_valid, "result lost")

endmodule
